[hw/rtl/adc_scan_moving_average_mv_top_assert.svh]
// Assertion macros for the ADC scan moving average block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef ADC_SCAN_MOVING_AVERAGE_MV_TOP_ASSERT_SVH
`define ADC_SCAN_MOVING_AVERAGE_MV_TOP_ASSERT_SVH

// same-cycle implication
`define ASMA_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("%m: check failed");

// next-cycle implication
`define ASMA_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("%m: check failed");

`endif

[hw/rtl/asma_pkg.sv]
// Package for the ADC scan moving average block: sizes, register codes,
// divider request/response types. No dependencies.
`timescale 1ns / 1ps
package asma_pkg;
	localparam int CHANNELS = 4;
	localparam int WINDOW   = 8;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int WP_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int SUM_W    = 12 + FILL_W;
	localparam int WIN_DEPTH = CHANNELS * WINDOW;
	localparam int WIN_AW   = $clog2(WIN_DEPTH);
	localparam int DIV_NW   = 36;
	localparam int DIV_DW   = 24;
	localparam int DIV_CW   = $clog2(DIV_NW + 1);

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_VCAL    = 2'd1;
	localparam logic [1:0] REG_VCH     = 2'd2;

	localparam logic [11:0] MV_SCALE = 12'd3000;
	localparam logic [11:0] FULL_CODE = 12'd4095;
	localparam logic [15:0] MV_LIMIT = 16'hFFFF;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_rsp_t;
endpackage

[hw/rtl/asma_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module asma_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/asma_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on asma_pkg.
`timescale 1ns / 1ps
module asma_div (
	input  logic                clk,
	input  logic                arst_n,
	input  asma_pkg::div_req_t  req,
	output asma_pkg::div_rsp_t  rsp
);
	import asma_pkg::*;

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic              fits;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_DW'(shifted - {1'b0, den_q}) : DIV_DW'(shifted);
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

[hw/rtl/adc_scan_moving_average_mv_top.sv]
// Samples and quiet ticks are taken in IDLE; a quiet tick that reaches the timeout
// emits a restart word. A scan tick runs per channel a window update (RAM read,
// write, divide), then per channel two millivolt conversions (2 multiply stages +
// divide each) and an output word; all divides use the shared bit-serial divider.
// arst_n clears all state; the window RAM is not cleared (fill count covers it).
`timescale 1ns / 1ps
module adc_scan_moving_average_mv_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // channel[1:0], sample[13:2], scan_done[14]
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_channel[1:0], raw_value[13:2],
	                               // filtered_value[25:14], raw_mv[41:26],
	                               // filtered_mv[57:42]
	output logic        m_tlast,   // last
	output logic        m_tuser,   // restarted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import asma_pkg::*;

	typedef enum logic [3:0] {
		IDLE, RD, UPD, FDIV, MUL1, MUL2, MVST, MVDIV, EMIT
	} state_t;

	state_t state_q;

	logic [7:0]  timeout_q;
	logic [11:0] vcal_q;
	logic [1:0]  vch_q;

	logic [11:0]      scan_q [CHANNELS];
	logic [11:0]      latest_q [CHANNELS];
	logic [11:0]      filt_q [CHANNELS];
	logic [SUM_W-1:0] sum_q [CHANNELS];
	logic [FILL_W-1:0] fill_q;
	logic [WP_W-1:0]  wp_q;
	logic [7:0]       idle_q;
	logic             restart_q;
	logic [CH_W-1:0]  ch_q;
	logic             sel_q;
	logic [15:0]      raw_mv_q;

	logic [23:0] p1_s1;
	logic [23:0] den_s1;
	logic        refz_s1;
	logic [35:0] num_s2;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic        m_tlast_q;
	logic        m_tuser_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [WIN_AW-1:0] win_addr;
	logic [11:0]       win_rdata;
	logic              win_we;

	logic              in_acc;
	logic              full;
	logic [FILL_W-1:0] cnt_new;
	logic [11:0]       evicted;
	logic [SUM_W-1:0]  sum_new;
	logic [7:0]        idle_new;
	logic              restart_new;
	logic              vch_ok;
	logic [11:0]       mv_val;
	logic [11:0]       mv_ref;
	logic [15:0]       mv_res;
	logic              last_ch;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;
	assign m_tuser   = m_tuser_q;

	assign full    = (fill_q == FILL_W'(WINDOW));
	assign cnt_new = full ? fill_q : fill_q + 1'b1;
	assign evicted = full ? win_rdata : 12'd0;
	assign sum_new = SUM_W'(sum_q[ch_q] - {{(SUM_W-12){1'b0}}, evicted}
		+ {{(SUM_W-12){1'b0}}, scan_q[ch_q]});
	assign win_addr = WIN_AW'(int'(ch_q) * WINDOW + int'(wp_q));
	assign win_we   = (state_q == UPD);
	assign last_ch  = (ch_q == CH_W'(CHANNELS - 1));

	assign idle_new    = (s_tdata[14] ? 8'd0 : idle_q) + 8'd1;
	assign restart_new = (idle_new >= timeout_q);

	assign vch_ok = (int'(vch_q) < CHANNELS);
	assign mv_val = sel_q ? filt_q[ch_q] : latest_q[ch_q];
	assign mv_ref = !vch_ok ? 12'd0 : (sel_q ? filt_q[CH_W'(vch_q)] : latest_q[CH_W'(vch_q)]);
	assign mv_res = (refz_s1 || (div_rsp.quot > DIV_NW'(MV_LIMIT))) ? MV_LIMIT
		: div_rsp.quot[15:0];

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = num_s2;
		div_req.den   = den_s1;
		if (state_q == UPD) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NW'(sum_new);
			div_req.den   = DIV_DW'(cnt_new);
		end else if (state_q == MVST) begin
			div_req.start = 1'b1;
		end
	end

	asma_ram #(.WIDTH(12), .DEPTH(WIN_DEPTH)) u_win (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_addr),
		.wdata (scan_q[ch_q]),
		.raddr (win_addr),
		.rdata (win_rdata)
	);

	asma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		p1_s1   <= mv_val * vcal_q;
		den_s1  <= mv_ref * FULL_CODE;
		refz_s1 <= (mv_ref == 12'd0);
		num_s2  <= p1_s1 * MV_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			timeout_q  <= 8'd50;
			vcal_q     <= 12'd1638;
			vch_q      <= 2'd0;
			for (int i = 0; i < CHANNELS; i++) begin
				scan_q[i]   <= '0;
				latest_q[i] <= '0;
				filt_q[i]   <= '0;
				sum_q[i]    <= '0;
			end
			fill_q     <= '0;
			wp_q       <= '0;
			idle_q     <= '0;
			restart_q  <= 1'b0;
			ch_q       <= '0;
			sel_q      <= 1'b0;
			raw_mv_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data[7:0];
					REG_VCAL:    vcal_q    <= cfg_data;
					REG_VCH:     vch_q     <= cfg_data[1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				IDLE: begin
					if (in_acc) begin
						if (!s_tuser) begin
							if (int'(s_tdata[1:0]) < CHANNELS) begin
								scan_q[CH_W'(s_tdata[1:0])] <= s_tdata[13:2];
							end
						end else begin
							idle_q    <= idle_new;
							restart_q <= restart_new;
							ch_q      <= '0;
							sel_q     <= 1'b0;
							if (s_tdata[14]) begin
								state_q <= RD;
							end else if (restart_new) begin
								m_tvalid_q <= 1'b1;
								m_tdata_q  <= '0;
								m_tlast_q  <= 1'b1;
								m_tuser_q  <= 1'b1;
								state_q    <= EMIT;
							end
						end
					end
				end
				RD: state_q <= UPD;
				UPD: begin
					latest_q[ch_q] <= scan_q[ch_q];
					sum_q[ch_q]    <= sum_new;
					state_q        <= FDIV;
				end
				FDIV: begin
					if (div_rsp.done) begin
						filt_q[ch_q] <= div_rsp.quot[11:0];
						if (last_ch) begin
							fill_q  <= cnt_new;
							wp_q    <= (int'(wp_q) == WINDOW - 1) ? '0 : wp_q + 1'b1;
							ch_q    <= '0;
							state_q <= MUL1;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= RD;
						end
					end
				end
				MUL1: state_q <= MUL2;
				MUL2: state_q <= MVST;
				MVST: state_q <= MVDIV;
				MVDIV: begin
					if (div_rsp.done) begin
						if (!sel_q) begin
							raw_mv_q <= mv_res;
							sel_q    <= 1'b1;
							state_q  <= MUL1;
						end else begin
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= {6'd0, mv_res, raw_mv_q, filt_q[ch_q],
								latest_q[ch_q], 2'(ch_q)};
							m_tlast_q  <= last_ch;
							m_tuser_q  <= restart_q;
							state_q    <= EMIT;
						end
					end
				end
				EMIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							if (restart_q) begin
								for (int i = 0; i < CHANNELS; i++) begin
									scan_q[i]   <= '0;
									latest_q[i] <= '0;
									filt_q[i]   <= '0;
									sum_q[i]    <= '0;
								end
								fill_q <= '0;
								wp_q   <= '0;
								idle_q <= '0;
							end
							state_q <= IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							sel_q   <= 1'b0;
							state_q <= MUL1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

[hw/rtl/asma_chk.sv]
// Port checker for the ADC scan moving average block, bound to the top level.
// Depends on asma_pkg and adc_scan_moving_average_mv_top_assert.svh.
`timescale 1ns / 1ps
`include "adc_scan_moving_average_mv_top_assert.svh"
module asma_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);
	import asma_pkg::*;

	`ASMA_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready)
	`ASMA_ASSERT_NEXT(a_sample_quiet, s_tvalid && s_tready && !s_tuser, !m_tvalid)
	`ASMA_ASSERT_IMPL(a_last_chan, m_tvalid && m_tlast && !m_tuser, m_tdata[1:0] == 2'(CHANNELS - 1))
	`ASMA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind adc_scan_moving_average_mv_top asma_chk u_asma_chk (.*);
